FILE: rtl/core/sltenc_pkg.sv
// ----------------------------------------------------------------------------
// sltenc_pkg
// Types, constants and helper functions shared by the segment LCD time
// encoder: font table, segment bit map, word masks and the command format.
// ----------------------------------------------------------------------------
package sltenc_pkg;

   localparam int WORD_W   = 30;
   localparam int NUM_COM  = 4;
   localparam int NUM_POS  = 6;
   localparam int NUM_SEG  = 4;
   localparam int FONT_W   = 16;

   typedef logic [WORD_W-1:0] lcd_word_type;
   typedef logic [FONT_W-1:0] font_word_type;

   typedef enum logic {
      OP_DRAW  = 1'b0,
      OP_COLON = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      EDIT_HOURS   = 2'd0,
      EDIT_MINUTES = 2'd1,
      EDIT_SECONDS = 2'd2,
      EDIT_NONE    = 2'd3
   } edit_field_type;

   // Colon dots sit at bits 7 and 11.
   localparam lcd_word_type COLON_MASK = 30'h0000_0880;
   // Every segment bit that a digit position owns.
   localparam lcd_word_type USED_MASK = 30'h3F3F_FF87;
   // Same, with the colon bits left alone (common lines 2 and 3).
   localparam lcd_word_type USED_MASK_NO_COLON = USED_MASK & ~COLON_MASK;

   // Word bit of segment b of digit position p.
   localparam logic [4:0] SEG_BIT [NUM_POS][NUM_SEG] = '{
      '{5'd0,  5'd1,  5'd28, 5'd29},
      '{5'd2,  5'd7,  5'd26, 5'd27},
      '{5'd8,  5'd9,  5'd24, 5'd25},
      '{5'd10, 5'd11, 5'd20, 5'd21},
      '{5'd12, 5'd13, 5'd18, 5'd19},
      '{5'd14, 5'd15, 5'd17, 5'd16}
   };

   // One queued command: the opcode, the colon request and six font codes.
   typedef struct packed {
      opcode_type                      opcode;
      logic                            colon_set;
      font_word_type [NUM_POS-1:0]     codes;
   } cmd_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] ones;
   } digit_pair_type;

   // Splits a value below 64 into two decimal digits. The tens digit comes
   // from a multiply by the reciprocal of ten, exact for this range.
   function automatic digit_pair_type split_digits(input logic [5:0] value);
      logic [13:0]    prod;
      logic [7:0]     tens_x10;
      digit_pair_type res;
      prod     = 14'(value) * 14'd205;
      res.tens = {1'b0, prod[13:11]};
      tens_x10 = 8'(res.tens) * 8'd10;
      res.ones = 4'(8'(value) - tens_x10);
      return res;
   endfunction

   function automatic font_word_type font_lookup(input logic [3:0] digit);
      font_word_type code;
      unique case (digit)
         4'd0:    code = 16'h5F00;
         4'd1:    code = 16'h4200;
         4'd2:    code = 16'hF500;
         4'd3:    code = 16'h6700;
         4'd4:    code = 16'hEA00;
         4'd5:    code = 16'hAF00;
         4'd6:    code = 16'hBF00;
         4'd7:    code = 16'h4600;
         4'd8:    code = 16'hFF00;
         4'd9:    code = 16'hEF00;
         default: code = '0;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/core/segment_lcd_time_encoder_core.sv
// A request beat is written into the command queue and then, once the response
// slot is free, applied to the registered RAM words that form the response beat.
// Throughput: one beat per cycle while responses are taken; the back end applies one command a cycle.
// Reset clears the four segment RAM words, the queue and the response slot.
// ----------------------------------------------------------------------------
// segment_lcd_time_encoder_core
// Seven-segment time encoder for a four-common segment LCD: draws hours,
// minutes and seconds into four 30-bit segment words and sets colon dots.
// ----------------------------------------------------------------------------
module segment_lcd_time_encoder_core import sltenc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [4:0]  req_hours,
   input  logic [5:0]  req_minutes,
   input  logic [5:0]  req_seconds,
   input  logic [1:0]  req_edit_field,
   input  logic        req_blank_edit,
   input  logic        req_colon_set,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [29:0] rsp_com0_word,
   output logic [29:0] rsp_com1_word,
   output logic [29:0] rsp_com2_word,
   output logic [29:0] rsp_com3_word
);

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_not_empty;

   sltenc_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_hours      (req_hours),
      .req_minutes    (req_minutes),
      .req_seconds    (req_seconds),
      .req_edit_field (req_edit_field),
      .req_blank_edit (req_blank_edit),
      .req_colon_set  (req_colon_set),
      .queue_full     (queue_full),
      .push           (push),
      .cmd            (front_cmd)
   );

   sltenc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   sltenc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (queue_not_empty),
      .cmd           (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_com0_word (rsp_com0_word),
      .rsp_com1_word (rsp_com1_word),
      .rsp_com2_word (rsp_com2_word),
      .rsp_com3_word (rsp_com3_word)
   );

endmodule

FILE: rtl/core/sltenc_front.sv
// ----------------------------------------------------------------------------
// sltenc_front
// Accepts request beats, splits the time values into digits and turns each
// digit into its font code, or a blank code, ready for the command queue.
// ----------------------------------------------------------------------------
module sltenc_front import sltenc_pkg::*; (
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [4:0] req_hours,
   input  logic [5:0] req_minutes,
   input  logic [5:0] req_seconds,
   input  logic [1:0] req_edit_field,
   input  logic       req_blank_edit,
   input  logic       req_colon_set,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    cmd
);

   digit_pair_type hours_dig;
   digit_pair_type minutes_dig;
   digit_pair_type seconds_dig;
   logic           blank_hours;
   logic           blank_minutes;
   logic           blank_seconds;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   assign hours_dig   = split_digits({1'b0, req_hours});
   assign minutes_dig = split_digits(req_minutes);
   assign seconds_dig = split_digits(req_seconds);

   assign blank_hours   = req_blank_edit && (edit_field_type'(req_edit_field) == EDIT_HOURS);
   assign blank_minutes = req_blank_edit && (edit_field_type'(req_edit_field) == EDIT_MINUTES);
   assign blank_seconds = req_blank_edit && (edit_field_type'(req_edit_field) == EDIT_SECONDS);

   always_comb begin
      cmd.opcode    = opcode_type'(req_opcode);
      cmd.colon_set = req_colon_set;
      cmd.codes[0]  = blank_hours   ? '0 : font_lookup(hours_dig.tens);
      cmd.codes[1]  = blank_hours   ? '0 : font_lookup(hours_dig.ones);
      cmd.codes[2]  = blank_minutes ? '0 : font_lookup(minutes_dig.tens);
      cmd.codes[3]  = blank_minutes ? '0 : font_lookup(minutes_dig.ones);
      cmd.codes[4]  = blank_seconds ? '0 : font_lookup(seconds_dig.tens);
      cmd.codes[5]  = blank_seconds ? '0 : font_lookup(seconds_dig.ones);
   end

endmodule

FILE: rtl/core/sltenc_queue.sv
// ----------------------------------------------------------------------------
// sltenc_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module sltenc_queue import sltenc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   cmd_type    slot_in [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/sltenc_back.sv
// ----------------------------------------------------------------------------
// sltenc_back
// Holds the four segment RAM words, applies one queued command per cycle while
// the response slot is free or being taken, and presents the updated words as the response beat.
// ----------------------------------------------------------------------------
module sltenc_back import sltenc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lcd_word_type rsp_com0_word,
   output lcd_word_type rsp_com1_word,
   output lcd_word_type rsp_com2_word,
   output lcd_word_type rsp_com3_word
);

   lcd_word_type ram_ff [NUM_COM];
   lcd_word_type ram_in [NUM_COM];
   lcd_word_type seg_bits [NUM_COM];
   logic         rsp_valid_ff;
   logic         rsp_valid_in;

   // The RAM words only change on a pop, and a pop only happens when the
   // response slot is free, so the words double as the response payload.
   assign pop = cmd_valid && (!rsp_valid_ff || rsp_ready);

   // Scatter nibble c of each font code, counted from the most significant end, onto common line c.
   always_comb begin
      for (int c = 0; c < NUM_COM; c++) begin
         seg_bits[c] = '0;
      end
      for (int p = 0; p < NUM_POS; p++) begin
         for (int b = 0; b < NUM_SEG; b++) begin
            for (int c = 0; c < NUM_COM; c++) begin
               seg_bits[c][SEG_BIT[p][b]] = cmd.codes[p][12 - 4 * c + b];
            end
         end
      end
   end

   always_comb begin
      ram_in = ram_ff;
      if (pop) begin
         if (cmd.opcode == OP_DRAW) begin
            for (int c = 0; c < NUM_COM; c++) begin
               if (c >= 2) begin
                  ram_in[c] = (ram_ff[c] & ~USED_MASK_NO_COLON) | seg_bits[c];
               end else begin
                  ram_in[c] = (ram_ff[c] & ~USED_MASK) | seg_bits[c];
               end
            end
         end else if (cmd.colon_set) begin
            ram_in[2] = ram_ff[2] | COLON_MASK;
         end else begin
            ram_in[2] = ram_ff[2] & ~COLON_MASK;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_COM; c++) begin
            ram_ff[c] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         ram_ff       <= ram_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_com0_word = ram_ff[0];
   assign rsp_com1_word = ram_ff[1];
   assign rsp_com2_word = ram_ff[2];
   assign rsp_com3_word = ram_ff[3];

endmodule

FILE: sim/segment_lcd_time_encoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_lcd_time_encoder_core_tb
// Drives draw and colon requests into the time encoder and compares every
// response beat with the four segment words from a local copy of the digit
// font, the segment bit map and the segment RAM. Both channels idle at random,
// the response side holds off once for a long stretch, and the request side
// drains the block twice before going on.
// ----------------------------------------------------------------------------
module segment_lcd_time_encoder_core_tb;
   import sltenc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_ITEMS  = 120;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 60;

   localparam font_word_type DIGIT_FONT [10] = '{
      16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
      16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
   };

   // Word bit of each of the four segments of the six digit positions.
   localparam int DIGIT_SEG [6][4] = '{
      '{0, 1, 28, 29},
      '{2, 7, 26, 27},
      '{8, 9, 24, 25},
      '{10, 11, 20, 21},
      '{12, 13, 18, 19},
      '{14, 15, 17, 16}
   };

   typedef struct {
      opcode_type     opcode;
      logic [4:0]     hours;
      logic [5:0]     minutes;
      logic [5:0]     seconds;
      edit_field_type edit_field;
      logic           blank_edit;
      logic           colon_set;
      bit             drain_first;
   } lcd_req_type;

   typedef struct {
      lcd_word_type com [NUM_COM];
   } lcd_words_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [4:0]  req_hours = '0;
   logic [5:0]  req_minutes = '0;
   logic [5:0]  req_seconds = '0;
   logic [1:0]  req_edit_field = '0;
   logic        req_blank_edit = 1'b0;
   logic        req_colon_set = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [29:0] rsp_com0_word;
   logic [29:0] rsp_com1_word;
   logic [29:0] rsp_com2_word;
   logic [29:0] rsp_com3_word;

   lcd_req_type   pending_reqs [$];
   lcd_words_type expected_words [$];
   lcd_word_type  seg_ram [NUM_COM] = '{default: '0};
   lcd_req_type   cur_req;
   bit            tx_busy = 1'b0;
   int            tx_idle = 0;
   int            rx_idle = 0;
   int            hold_left = 0;
   bit            hold_done = 1'b0;
   int            rsp_count = 0;
   int            err_count = 0;
   int            cycle_count = 0;

   segment_lcd_time_encoder_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_hours      (req_hours),
      .req_minutes    (req_minutes),
      .req_seconds    (req_seconds),
      .req_edit_field (req_edit_field),
      .req_blank_edit (req_blank_edit),
      .req_colon_set  (req_colon_set),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_com0_word  (rsp_com0_word),
      .rsp_com1_word  (rsp_com1_word),
      .rsp_com2_word  (rsp_com2_word),
      .rsp_com3_word  (rsp_com3_word)
   );

   always #6 clock = ~clock;

   task automatic report_error(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   // Writes one font code into a digit position. Lines 2 and 3 never lose a
   // colon bit here, although a lit segment can still set one.
   function automatic void put_digit(input int pos, input font_word_type code);
      lcd_word_type used;
      lcd_word_type keep;
      lcd_word_type lit [NUM_COM];
      used = '0;
      lit = '{default: '0};
      for (int b = 0; b < NUM_SEG; b++) begin
         used[DIGIT_SEG[pos][b]] = 1'b1;
         for (int c = 0; c < NUM_COM; c++) begin
            if (code[12 - 4 * c + b])
               lit[c][DIGIT_SEG[pos][b]] = 1'b1;
         end
      end
      for (int c = 0; c < NUM_COM; c++) begin
         keep = (c >= 2) ? (used & ~COLON_MASK) : used;
         seg_ram[c] = (seg_ram[c] & ~keep) | lit[c];
      end
   endfunction

   function automatic void put_pair(input int pos, input int value, input bit blank);
      if (blank) begin
         put_digit(pos, '0);
         put_digit(pos + 1, '0);
      end else begin
         put_digit(pos, DIGIT_FONT[(value / 10) % 10]);
         put_digit(pos + 1, DIGIT_FONT[value % 10]);
      end
   endfunction

   function automatic void encode_request(input lcd_req_type r);
      lcd_words_type w;
      if (r.opcode == OP_DRAW) begin
         put_pair(0, int'(r.hours), r.blank_edit && r.edit_field == EDIT_HOURS);
         put_pair(2, int'(r.minutes), r.blank_edit && r.edit_field == EDIT_MINUTES);
         put_pair(4, int'(r.seconds), r.blank_edit && r.edit_field == EDIT_SECONDS);
      end else if (r.colon_set) begin
         seg_ram[2] = seg_ram[2] | COLON_MASK;
      end else begin
         seg_ram[2] = seg_ram[2] & ~COLON_MASK;
      end
      for (int c = 0; c < NUM_COM; c++)
         w.com[c] = seg_ram[c];
      expected_words.push_back(w);
   endfunction

   function automatic void queue_req(input opcode_type op, input int h, input int m,
                                     input int s, input edit_field_type f, input bit blank,
                                     input bit colon, input bit drain);
      lcd_req_type r;
      r.opcode      = op;
      r.hours       = h[4:0];
      r.minutes     = m[5:0];
      r.seconds     = s[5:0];
      r.edit_field  = f;
      r.blank_edit  = blank;
      r.colon_set   = colon;
      r.drain_first = drain;
      pending_reqs.push_back(r);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            encode_request(cur_req);
            tx_busy = 1'b0;
         end
         if (!tx_busy) begin
            if (tx_idle > 0) begin
               tx_idle--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain_first && expected_words.size() != 0)) begin
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
               tx_idle = $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else begin
               cur_req = pending_reqs.pop_front();
               req_opcode     <= cur_req.opcode;
               req_hours      <= cur_req.hours;
               req_minutes    <= cur_req.minutes;
               req_seconds    <= cur_req.seconds;
               req_edit_field <= cur_req.edit_field;
               req_blank_edit <= cur_req.blank_edit;
               req_colon_set  <= cur_req.colon_set;
               req_valid      <= 1'b1;
               tx_busy = 1'b1;
            end
         end
      end
   end

   // Response monitor and ready driver.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_words.size() == 0) begin
               report_error("response beat with nothing outstanding");
            end else begin
               lcd_words_type w;
               w = expected_words.pop_front();
               if (rsp_com0_word !== w.com[0])
                  report_error($sformatf("com0 got %h want %h", rsp_com0_word, w.com[0]));
               if (rsp_com1_word !== w.com[1])
                  report_error($sformatf("com1 got %h want %h", rsp_com1_word, w.com[1]));
               if (rsp_com2_word !== w.com[2])
                  report_error($sformatf("com2 got %h want %h", rsp_com2_word, w.com[2]));
               if (rsp_com3_word !== w.com[3])
                  report_error($sformatf("com3 got %h want %h", rsp_com3_word, w.com[3]));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_count >= HOLD_AT) begin
            // Long stall so the block fills up and pushes back on requests.
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (rx_idle > 0) begin
            rx_idle--;
            rsp_ready <= 1'b0;
         end else if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            rx_idle = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      int         h;
      int         m;
      int         s;
      bit         wide;
      opcode_type op;

      // Directed: field extremes, out-of-range values, each blank choice and
      // colon handling around draws.
      queue_req(OP_DRAW, 0, 0, 0, EDIT_NONE, 1'b0, 1'b0, 1'b0);
      queue_req(OP_DRAW, 23, 59, 59, EDIT_NONE, 1'b0, 1'b0, 1'b0);
      queue_req(OP_DRAW, 31, 63, 63, EDIT_NONE, 1'b0, 1'b1, 1'b0);
      queue_req(OP_COLON, 0, 0, 0, EDIT_NONE, 1'b0, 1'b1, 1'b0);
      queue_req(OP_DRAW, 12, 34, 56, EDIT_NONE, 1'b1, 1'b0, 1'b0);
      queue_req(OP_DRAW, 8, 8, 8, EDIT_HOURS, 1'b1, 1'b0, 1'b0);
      queue_req(OP_DRAW, 18, 48, 38, EDIT_MINUTES, 1'b1, 1'b1, 1'b0);
      queue_req(OP_DRAW, 28, 58, 18, EDIT_SECONDS, 1'b1, 1'b0, 1'b0);
      queue_req(OP_COLON, 31, 63, 63, EDIT_NONE, 1'b1, 1'b0, 1'b0);
      queue_req(OP_DRAW, 10, 20, 30, EDIT_HOURS, 1'b0, 1'b0, 1'b0);
      queue_req(OP_COLON, 31, 63, 63, EDIT_NONE, 1'b1, 1'b1, 1'b0);
      queue_req(OP_COLON, 0, 0, 0, EDIT_HOURS, 1'b0, 1'b1, 1'b0);
      for (int d = 0; d < 10; d++)
         queue_req(OP_DRAW, d + 20 * (d % 2), 10 * (d % 6) + d, 10 * ((d + 3) % 6) + 9 - d,
                   EDIT_NONE, 1'b0, 1'b0, 1'b0);

      for (int i = 0; i < 1530; i++) begin
         op   = ($urandom_range(0, 3) == 0) ? OP_COLON : OP_DRAW;
         wide = ($urandom_range(0, 3) == 0);
         h    = wide ? $urandom_range(0, 31) : $urandom_range(0, 23);
         m    = wide ? $urandom_range(0, 63) : $urandom_range(0, 59);
         s    = wide ? $urandom_range(0, 63) : $urandom_range(0, 59);
         queue_req(op, h, m, s, edit_field_type'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   i == 0 || i == 800);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || tx_busy || expected_words.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (err_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
